@@ rtl/core/comb_sort_with_swap_count_defines.svh @@
// Assertion macros shared by the comb sort RTL.
`ifndef COMB_SORT_WITH_SWAP_COUNT_DEFINES_SVH
`define COMB_SORT_WITH_SWAP_COUNT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSWC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cswc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cswc assertion failed");

`endif

@@ rtl/core/cswc_pkg.sv @@
// Shared types and constants of the comb sort block.
`default_nettype none

package cswc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned SWAP_W    = 16;
	// gap*10/13 is taken as (gap * 50420) >> 16, exact for gaps up to 64
	localparam int unsigned GAP_MUL   = 50420;
	localparam int unsigned GAP_SHIFT = 16;

	typedef enum logic [2:0] {
		TOP_LOAD,
		TOP_SORT,
		TOP_EMIT_RD,
		TOP_EMIT_LD,
		TOP_EMIT_WAIT
	} top_state_t;

	typedef enum logic [2:0] {
		SRT_IDLE,
		SRT_GAP,
		SRT_RD,
		SRT_CMP,
		SRT_WR2,
		SRT_DONE
	} sort_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sort_status_t;

endpackage

`default_nettype wire

@@ rtl/core/cswc_if.sv @@
// Stream interfaces for the input elements and the sorted results.
`default_nettype none

interface cswc_in_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        value;
	logic                      last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

interface cswc_out_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        sorted_value;
	logic                      final_res;
	logic [15:0]               swap_total;

	modport source (output valid, sorted_value, final_res, swap_total, input ready);
	modport sink   (input valid, sorted_value, final_res, swap_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cswc_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module cswc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ rtl/core/cswc_sorter.sv @@
// Comb sort sequencer: walks the store pass by pass, compares and swaps in place.
`default_nettype none

module cswc_sorter #(
	parameter int unsigned MAX_ITEMS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [$clog2(MAX_ITEMS+1)-1:0] n,
	output cswc_pkg::sort_status_t              status,
	output logic [cswc_pkg::SWAP_W-1:0]         swaps,
	output logic                                we,
	output logic [$clog2(MAX_ITEMS)-1:0]        waddr,
	output logic [cswc_pkg::DATA_W-1:0]         wdata,
	output logic [$clog2(MAX_ITEMS)-1:0]        raddr_a,
	output logic [$clog2(MAX_ITEMS)-1:0]        raddr_b,
	input  wire logic [cswc_pkg::DATA_W-1:0]    rdata_a,
	input  wire logic [cswc_pkg::DATA_W-1:0]    rdata_b
);

	localparam int unsigned IW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned PW = CW + cswc_pkg::GAP_SHIFT;

	cswc_pkg::sort_state_t state_q, state_d;

	logic [CW-1:0]               gap_q;
	logic [IW-1:0]               i_q;
	logic                        swapped_q;
	logic [cswc_pkg::SWAP_W-1:0] swaps_q;
	logic [cswc_pkg::DATA_W-1:0] hold_q;

	logic [PW-1:0] gap_prod;
	logic [CW-1:0] gap_quo;
	logic [CW-1:0] gap_new;
	logic [CW:0]   pair_sum;
	logic          last_pair;
	logic          do_swap;
	logic          pass_done;

	// shrink the gap by 10/13 and floor it at 1
	assign gap_prod = PW'(gap_q) * PW'(cswc_pkg::GAP_MUL);
	assign gap_quo  = gap_prod[PW-1:cswc_pkg::GAP_SHIFT];
	assign gap_new  = (gap_quo == '0) ? CW'(1) : gap_quo;

	assign pair_sum  = (CW+1)'(i_q) + (CW+1)'(gap_q);
	assign last_pair = (pair_sum + (CW+1)'(1)) >= (CW+1)'(n);
	assign do_swap   = $signed(rdata_a) > $signed(rdata_b);
	assign pass_done = (gap_q == CW'(1)) && !swapped_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cswc_pkg::SRT_IDLE: begin
				if (start) begin
					state_d = cswc_pkg::SRT_GAP;
				end
			end
			cswc_pkg::SRT_GAP: begin
				if (CW'(gap_new) < n) begin
					state_d = cswc_pkg::SRT_RD;
				end else if (gap_new == CW'(1)) begin
					state_d = cswc_pkg::SRT_DONE;
				end else begin
					state_d = cswc_pkg::SRT_GAP;
				end
			end
			cswc_pkg::SRT_RD: begin
				state_d = cswc_pkg::SRT_CMP;
			end
			cswc_pkg::SRT_CMP: begin
				if (do_swap) begin
					state_d = cswc_pkg::SRT_WR2;
				end else if (!last_pair) begin
					state_d = cswc_pkg::SRT_RD;
				end else if (pass_done) begin
					state_d = cswc_pkg::SRT_DONE;
				end else begin
					state_d = cswc_pkg::SRT_GAP;
				end
			end
			cswc_pkg::SRT_WR2: begin
				state_d = last_pair ? cswc_pkg::SRT_GAP : cswc_pkg::SRT_RD;
			end
			cswc_pkg::SRT_DONE: begin
				state_d = cswc_pkg::SRT_IDLE;
			end
			default: begin
				state_d = cswc_pkg::SRT_IDLE;
			end
		endcase
	end

	always_comb begin
		we      = 1'b0;
		waddr   = i_q;
		wdata   = rdata_b;
		raddr_a = i_q;
		raddr_b = pair_sum[IW-1:0];
		unique case (state_q)
			cswc_pkg::SRT_CMP: begin
				we = do_swap;
			end
			cswc_pkg::SRT_WR2: begin
				we    = 1'b1;
				waddr = pair_sum[IW-1:0];
				wdata = hold_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		status.busy = (state_q != cswc_pkg::SRT_IDLE);
		status.done = (state_q == cswc_pkg::SRT_DONE);
		swaps       = swaps_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cswc_pkg::SRT_IDLE;
			gap_q     <= '0;
			i_q       <= '0;
			swapped_q <= 1'b0;
			swaps_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cswc_pkg::SRT_IDLE: begin
					if (start) begin
						gap_q   <= n;
						swaps_q <= '0;
					end
				end
				cswc_pkg::SRT_GAP: begin
					gap_q     <= gap_new;
					i_q       <= '0;
					swapped_q <= 1'b0;
				end
				cswc_pkg::SRT_CMP: begin
					if (do_swap) begin
						swapped_q <= 1'b1;
						if (swaps_q != '1) begin
							swaps_q <= swaps_q + 1'b1;
						end
					end else if (!last_pair) begin
						i_q <= i_q + 1'b1;
					end
				end
				cswc_pkg::SRT_WR2: begin
					if (!last_pair) begin
						i_q <= i_q + 1'b1;
					end
				end
				cswc_pkg::SRT_DONE: begin
					gap_q     <= '0;
					swapped_q <= 1'b0;
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cswc_pkg::SRT_CMP) begin
			hold_q <= rdata_a;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/comb_sort_with_swap_count.sv @@
// Comb sort with swap count: load, sort in a RAM, emit the sorted burst.
// Load: one request per cycle while loading; a last-marked one starts the sort.
// Sort: a start state, then per pass a gap update, a read and a compare per
// pair, a second write per swapped pair, and a done state after the final pass.
// Emit: a read, a load and a wait for acceptance per result; one set at a time.
// Reset clears all control state; the element RAM is not cleared and holds
// garbage until loaded (only loaded entries are ever read).
`default_nettype none
`include "comb_sort_with_swap_count_defines.svh"

module comb_sort_with_swap_count #(
	parameter int unsigned MAX_ITEMS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cswc_in_if.sink     elem,
	cswc_out_if.source  res
);

	localparam int unsigned IW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	cswc_pkg::top_state_t state_q, state_d;

	// element count of the current set and emit index
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q;

	// output register
	logic                        res_valid_q;
	logic [cswc_pkg::DATA_W-1:0] res_value_q;
	logic                        res_final_q;
	logic [cswc_pkg::SWAP_W-1:0] res_swaps_q;

	logic elem_acc;
	logic res_acc;
	logic sort_start;
	logic emit_final;

	cswc_pkg::sort_status_t       sort_st;
	logic [cswc_pkg::SWAP_W-1:0]  sort_swaps;
	logic                         srt_we;
	logic [IW-1:0]                srt_waddr;
	logic [cswc_pkg::DATA_W-1:0]  srt_wdata;
	logic [IW-1:0]                srt_raddr_a;
	logic [IW-1:0]                srt_raddr_b;

	// RAM port, muxed between load/emit and the sorter
	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;
	logic [cswc_pkg::DATA_W-1:0] ram_wdata;
	logic [IW-1:0]               ram_raddr_a;
	logic [IW-1:0]               ram_raddr_b;
	logic [cswc_pkg::DATA_W-1:0] ram_rdata_a;
	logic [cswc_pkg::DATA_W-1:0] ram_rdata_b;

	assign elem_acc   = elem.valid && elem.ready;
	assign res_acc    = res.valid && res.ready;
	assign emit_final = (CW'(k_q) + CW'(1)) == count_q;

	cswc_ram #(
		.WIDTH (cswc_pkg::DATA_W),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	cswc_sorter #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_sorter (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sort_start),
		.n       (count_q),
		.status  (sort_st),
		.swaps   (sort_swaps),
		.we      (srt_we),
		.waddr   (srt_waddr),
		.wdata   (srt_wdata),
		.raddr_a (srt_raddr_a),
		.raddr_b (srt_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cswc_pkg::TOP_LOAD: begin
				if (elem_acc && elem.last) begin
					state_d = cswc_pkg::TOP_SORT;
				end
			end
			cswc_pkg::TOP_SORT: begin
				if (sort_st.done) begin
					state_d = cswc_pkg::TOP_EMIT_RD;
				end
			end
			cswc_pkg::TOP_EMIT_RD: begin
				state_d = cswc_pkg::TOP_EMIT_LD;
			end
			cswc_pkg::TOP_EMIT_LD: begin
				state_d = cswc_pkg::TOP_EMIT_WAIT;
			end
			cswc_pkg::TOP_EMIT_WAIT: begin
				if (res_acc) begin
					state_d = res_final_q ? cswc_pkg::TOP_LOAD : cswc_pkg::TOP_EMIT_RD;
				end
			end
			default: begin
				state_d = cswc_pkg::TOP_LOAD;
			end
		endcase
	end

	// outputs: handshake and RAM port selection
	always_comb begin
		elem.ready  = (state_q == cswc_pkg::TOP_LOAD);
		sort_start  = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = count_q[IW-1:0];
		ram_wdata   = elem.value;
		ram_raddr_a = k_q;
		ram_raddr_b = k_q;
		unique case (state_q)
			cswc_pkg::TOP_LOAD: begin
				// drop values once the store is full
				ram_we = elem_acc && (count_q < CW'(MAX_ITEMS));
			end
			cswc_pkg::TOP_SORT: begin
				// start once the count includes the request marked last
				sort_start  = !sort_st.busy;
				ram_we      = srt_we;
				ram_waddr   = srt_waddr;
				ram_wdata   = srt_wdata;
				ram_raddr_a = srt_raddr_a;
				ram_raddr_b = srt_raddr_b;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cswc_pkg::TOP_LOAD;
			count_q     <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cswc_pkg::TOP_LOAD: begin
					if (elem_acc && (count_q < CW'(MAX_ITEMS))) begin
						count_q <= count_q + 1'b1;
					end
					k_q <= '0;
				end
				cswc_pkg::TOP_EMIT_LD: begin
					res_valid_q <= 1'b1;
				end
				cswc_pkg::TOP_EMIT_WAIT: begin
					if (res_acc) begin
						res_valid_q <= 1'b0;
						if (res_final_q) begin
							// burst finished: start a new set
							count_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// result payload, loaded from the RAM read register
	always_ff @(posedge clk) begin
		if (state_q == cswc_pkg::TOP_EMIT_LD) begin
			res_value_q <= ram_rdata_a;
			res_final_q <= emit_final;
			res_swaps_q <= sort_swaps;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.sorted_value = res_value_q;
	assign res.final_res    = res_final_q;
	assign res.swap_total   = res_swaps_q;

	`CSWC_ASSERT_IMPL(a_load_while_idle, clk, arst_n, elem.ready, !sort_st.busy)
	`CSWC_ASSERT_IMPL(a_valid_in_wait, clk, arst_n, res.valid, state_q == cswc_pkg::TOP_EMIT_WAIT)
	`CSWC_ASSERT_NEXT(a_start_busy, clk, arst_n, sort_start, sort_st.busy)
	`CSWC_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_ITEMS))
	`CSWC_ASSERT_NEXT(a_final_reload, clk, arst_n, res_acc && res.final_res,
		state_q == cswc_pkg::TOP_LOAD && count_q == '0)

endmodule

`default_nettype wire
